@@ rtl/kped_pkg.sv @@
// ----------------------------------------------------------------------------
// kped_pkg
// Shared types and codes for the key press event detector: beat payloads,
// per-key state word, key phases and event codes.
// ----------------------------------------------------------------------------
package kped_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_LONG_PRESS_TICKS   = 2'd0;
    localparam logic [1:0] CFG_KEY_ENABLE_MASK    = 2'd1;
    localparam logic [1:0] CFG_PRESSED_LEVEL_MASK = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int KEY_W      = 3;
    localparam int COUNT_W    = 16;
    localparam int MASK_W     = 8;

    // event codes
    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_UP   = 2'd1;
    localparam logic [1:0] EV_LONG = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CONFIRM = 3'd1,
        PH_DOWN    = 3'd2,
        PH_LONG    = 3'd3,
        PH_UP      = 3'd4
    } t_phase;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             pin_level;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] event_key;
        logic [1:0]       key_event;
    } t_out_item;

    // one key's stored state
    typedef struct packed {
        logic               pressed_now;
        t_phase             key_phase;
        logic [COUNT_W-1:0] hold_count;
    } t_key_state;

    // event decision from the update logic
    typedef struct packed {
        logic       fire;
        logic [1:0] code;
    } t_key_event;

    localparam t_key_state KEY_STATE_RESET = '{
        pressed_now: 1'b0,
        key_phase:   PH_IDLE,
        hold_count:  '0
    };

endpackage

@@ rtl/kped_state_mem.sv @@
// ----------------------------------------------------------------------------
// kped_state_mem
// Per-key state memory with registered read, per-entry valid bits
// that stand for the reset value, and forwarding of the latest write.
// ----------------------------------------------------------------------------
module kped_state_mem #(
    parameter int NUM_KEYS = 8,
    parameter int KEY_AW   = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [KEY_AW-1:0]      i_rd_addr,
    input  logic                   i_wr_en,
    input  logic [KEY_AW-1:0]      i_wr_addr,
    input  kped_pkg::t_key_state   i_wr_data,
    output kped_pkg::t_key_state   o_rd_data
);
    import kped_pkg::*;

    t_key_state                 r_mem [NUM_KEYS];
    t_key_state                 r_rd_raw;
    logic [KEY_AW-1:0]          r_rd_addr;
    logic [NUM_KEYS-1:0]        r_valid;
    logic                       r_fwd_valid;
    logic [KEY_AW-1:0]          r_fwd_addr;
    t_key_state                 r_fwd_data;

    // storage array, written and read in one clocked block
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw  <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // valid bits and last-write bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fwd_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
            r_fwd_valid        <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    // newest value wins: bypass, then stored entry, then reset value
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_rd_addr)) begin
            o_rd_data = r_fwd_data;
        end else if (r_valid[r_rd_addr]) begin
            o_rd_data = r_rd_raw;
        end else begin
            o_rd_data = KEY_STATE_RESET;
        end
    end

endmodule

@@ rtl/kped_update.sv @@
// ----------------------------------------------------------------------------
// kped_update
// Next-state and event logic for one key: pressed level, debounce phase
// and saturating hold counter.
// ----------------------------------------------------------------------------
module kped_update (
    input  kped_pkg::t_key_state              i_state,
    input  logic                              i_pin_level,
    input  logic                              i_key_enable,
    input  logic                              i_pressed_level,
    input  logic [kped_pkg::COUNT_W-1:0]      i_long_ticks,
    output kped_pkg::t_key_state              o_state,
    output kped_pkg::t_key_event              o_event
);
    import kped_pkg::*;

    logic               pr;
    logic [COUNT_W-1:0] count_inc;

    // disabled keys keep their last level
    assign pr = i_key_enable ? (i_pin_level == i_pressed_level) : i_state.pressed_now;

    // counter stops at all ones
    assign count_inc = (i_state.hold_count == '1) ? i_state.hold_count
                                                  : i_state.hold_count + 1'b1;

    // phase machine
    always_comb begin
        o_state             = i_state;
        o_state.pressed_now = pr;
        o_event.fire        = 1'b0;
        o_event.code        = EV_DOWN;
        unique case (i_state.key_phase)
            PH_CONFIRM: begin
                if (pr) begin
                    o_state.key_phase  = PH_DOWN;
                    o_state.hold_count = '0;
                    o_event.fire       = 1'b1;
                    o_event.code       = EV_DOWN;
                end else begin
                    o_state.key_phase = PH_IDLE;
                end
            end
            PH_DOWN: begin
                if (!pr) begin
                    o_state.key_phase = PH_UP;
                    o_event.fire      = 1'b1;
                    o_event.code      = EV_UP;
                end else begin
                    o_state.hold_count = count_inc;
                    if (count_inc >= i_long_ticks) begin
                        o_state.key_phase = PH_LONG;
                        o_event.fire      = 1'b1;
                        o_event.code      = EV_LONG;
                    end
                end
            end
            PH_LONG: begin
                if (!pr) begin
                    o_state.key_phase = PH_UP;
                    o_event.fire      = 1'b1;
                    o_event.code      = EV_UP;
                end
            end
            PH_UP: begin
                if (!pr) begin
                    o_state.key_phase  = PH_IDLE;
                    o_state.hold_count = '0;
                end else begin
                    // press seen again while up repeats the up event
                    o_event.fire = 1'b1;
                    o_event.code = EV_UP;
                end
            end
            default: begin
                o_state.key_phase = pr ? PH_CONFIRM : PH_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/key_press_event_detector_top.sv @@
// ----------------------------------------------------------------------------
// key_press_event_detector_top
// Per-key press detector: each scan sample reads its key's state from
// memory, updates it and writes it back, giving down, up and long events.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------
//   in       | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//   out      | output    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//   cfg      | input     | i_cfg_we                | i_cfg_index, i_cfg_wdata
//
// One sample per cycle while o_in_stall is low; an event reaches the output
// register after its sample passes the registered state memory read and the
// update stage; same-key samples in a row are served by write bypass.
// Reset clears key state at once through per-entry valid bits, no sweep.
// An output stall holds the update stage only when it has an event to give.
// ----------------------------------------------------------------------------
module key_press_event_detector_top #(
    parameter int NUM_KEYS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  kped_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output kped_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [kped_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import kped_pkg::*;

    localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // configuration registers
    logic [COUNT_W-1:0] r_long_ticks;
    logic [MASK_W-1:0]  r_en_mask;
    logic [MASK_W-1:0]  r_lvl_mask;

    // update stage
    logic               r_s1_valid;
    logic               r_s1_in_range;
    t_in_item           r_s1_item;

    // output register
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               in_acc;
    logic               s1_go;
    logic               s1_fire;
    logic               wr_en;
    t_key_state         rd_state;
    t_key_state         n_state;
    t_key_event         upd_event;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= 16'd40;
            r_en_mask    <= 8'hFF;
            r_lvl_mask   <= 8'h00;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LONG_PRESS_TICKS:   r_long_ticks <= i_cfg_wdata;
                CFG_KEY_ENABLE_MASK:    r_en_mask    <= i_cfg_wdata[MASK_W-1:0];
                CFG_PRESSED_LEVEL_MASK: r_lvl_mask   <= i_cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake and stage advance
    assign s1_fire    = r_s1_valid && r_s1_in_range && upd_event.fire;
    assign s1_go      = r_s1_valid && (!s1_fire || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_en      = s1_go && r_s1_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || s1_go) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item     <= i_in_item;
            r_s1_in_range <= (32'(i_in_item.key_index) < NUM_KEYS);
        end
    end

    // state memory
    kped_state_mem #(
        .NUM_KEYS (NUM_KEYS),
        .KEY_AW   (KEY_AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (KEY_AW'(i_in_item.key_index)),
        .i_wr_en   (wr_en),
        .i_wr_addr (KEY_AW'(r_s1_item.key_index)),
        .i_wr_data (n_state),
        .o_rd_data (rd_state)
    );

    // per-key update
    kped_update u_upd (
        .i_state         (rd_state),
        .i_pin_level     (r_s1_item.pin_level),
        .i_key_enable    (r_en_mask[r_s1_item.key_index]),
        .i_pressed_level (r_lvl_mask[r_s1_item.key_index]),
        .i_long_ticks    (r_long_ticks),
        .o_state         (n_state),
        .o_event         (upd_event)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_fire) begin
            r_out_item.event_key <= r_s1_item.key_index;
            r_out_item.key_event <= upd_event.code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/kped_checker.sv @@
// ----------------------------------------------------------------------------
// kped_checker
// Port-level checks for the key press event detector, bound to the top.
// ----------------------------------------------------------------------------
module kped_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  kped_pkg::t_in_item                i_in_item,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  kped_pkg::t_out_item               o_out_item
);
    import kped_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a fresh result traces back to an accepted sample
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a sample two edges earlier");

    a_event_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_item.event_key == $past(i_in_item.key_index, 2)))
        else $error("result key differs from sample key");

endmodule

bind key_press_event_detector_top kped_checker u_kped_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ tb/key_press_event_detector_top_tb.sv @@
// ----------------------------------------------------------------------------
// key_press_event_detector_top_tb
// Self-checking bench for the key press event detector. A scripted table
// covers the basic press, long, release and repeat-up paths with events typed
// in. Randomized phases follow under several register settings, including
// all-disabled keys and a zero threshold, then a hold at the full 16-bit threshold.
// Every accepted sample runs through a per-key tracker; random rows queue the
// event it expects. Each output beat is compared against the oldest queued event.
// ----------------------------------------------------------------------------
module key_press_event_detector_top_tb;
    import kped_pkg::*;

    localparam int NUM_KEYS    = 8;
    localparam int SETTLE_CYC  = 6;
    localparam int WDOG_LIMIT  = 2000;
    localparam int MAX_PRINTS  = 40;
    localparam int SCRIPT_LEN  = 25;
    localparam int HOLD_BEATS  = 40;

    // how a scripted row is checked
    typedef enum logic [1:0] {
        ROW_FOLLOW = 2'd0,
        ROW_QUIET  = 2'd1,
        ROW_EVENT  = 2'd2
    } t_row_kind;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             pin;
        t_row_kind        kind;
        logic [1:0]       code;
    } t_script_row;

    // receiver stall styles
    typedef enum logic [1:0] {
        STALL_NONE  = 2'd0,
        STALL_HALF  = 2'd1,
        STALL_HEAVY = 2'd2,
        STALL_WAVE  = 2'd3
    } t_stall_style;

    // script runs with ticks 2, all keys enabled, key 7 pressed on a high pin
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{3'd0, 1'b1, ROW_QUIET,  EV_DOWN},  // released while idle
        '{3'd0, 1'b0, ROW_QUIET,  EV_DOWN},  // first pressed sample
        '{3'd0, 1'b0, ROW_EVENT,  EV_DOWN},
        '{3'd0, 1'b0, ROW_QUIET,  EV_DOWN},  // hold 1, below threshold
        '{3'd0, 1'b0, ROW_EVENT,  EV_LONG},
        '{3'd0, 1'b0, ROW_QUIET,  EV_DOWN},  // long held, no event
        '{3'd0, 1'b1, ROW_EVENT,  EV_UP},
        '{3'd0, 1'b0, ROW_EVENT,  EV_UP},    // pressed again while up
        '{3'd0, 1'b1, ROW_QUIET,  EV_DOWN},  // up back to idle
        '{3'd0, 1'b0, ROW_QUIET,  EV_DOWN},
        '{3'd0, 1'b1, ROW_QUIET,  EV_DOWN},  // one-sample glitch
        '{3'd7, 1'b1, ROW_QUIET,  EV_DOWN},
        '{3'd7, 1'b1, ROW_EVENT,  EV_DOWN},
        '{3'd7, 1'b0, ROW_EVENT,  EV_UP},
        '{3'd7, 1'b0, ROW_QUIET,  EV_DOWN},
        '{3'd3, 1'b0, ROW_QUIET,  EV_DOWN},  // two keys interleaved
        '{3'd4, 1'b0, ROW_QUIET,  EV_DOWN},
        '{3'd3, 1'b0, ROW_EVENT,  EV_DOWN},
        '{3'd4, 1'b1, ROW_QUIET,  EV_DOWN},
        '{3'd3, 1'b1, ROW_EVENT,  EV_UP},
        '{3'd3, 1'b1, ROW_QUIET,  EV_DOWN},
        '{3'd2, 1'b0, ROW_FOLLOW, EV_DOWN},
        '{3'd2, 1'b0, ROW_FOLLOW, EV_DOWN},
        '{3'd2, 1'b0, ROW_FOLLOW, EV_DOWN},
        '{3'd2, 1'b1, ROW_FOLLOW, EV_DOWN}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in_item              in_item     = '0;
    logic                  out_stall   = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [1:0]            cfg_index   = CFG_LONG_PRESS_TICKS;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;

    // register shadows, reset values
    logic [COUNT_W-1:0] ticks_m  = 16'd40;
    logic [MASK_W-1:0]  key_on_m = 8'hFF;
    logic [MASK_W-1:0]  level_m  = 8'h00;

    // per-key tracker state
    t_phase             phase_m [NUM_KEYS];
    logic [COUNT_W-1:0] hold_m  [NUM_KEYS];
    logic               held_m  [NUM_KEYS];
    logic [NUM_KEYS-1:0] want_press = '0;

    t_out_item   pending_events [$];
    int unsigned error_count = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_span  = 0;
    t_stall_style stall_style = STALL_NONE;

    key_press_event_detector_top #(
        .NUM_KEYS (NUM_KEYS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            phase_m[k] = PH_IDLE;
            hold_m[k]  = '0;
            held_m[k]  = 1'b0;
        end
    end

    task automatic log_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // advance one key's debounce tracker, return the event it gives
    function automatic t_key_event track_key(input t_in_item s);
        t_key_event r;
        int unsigned k;
        logic p;
        r.fire = 1'b0;
        r.code = EV_DOWN;
        k = s.key_index;
        if (key_on_m[k]) held_m[k] = (s.pin_level == level_m[k]);
        p = held_m[k];
        case (phase_m[k])
            PH_CONFIRM: begin
                if (p) begin
                    phase_m[k] = PH_DOWN;
                    hold_m[k]  = '0;
                    r.fire = 1'b1;
                    r.code = EV_DOWN;
                end else begin
                    phase_m[k] = PH_IDLE;
                end
            end
            PH_DOWN: begin
                if (!p) begin
                    phase_m[k] = PH_UP;
                    r.fire = 1'b1;
                    r.code = EV_UP;
                end else begin
                    if (hold_m[k] != 16'hFFFF) hold_m[k] = hold_m[k] + 16'd1;
                    if (hold_m[k] >= ticks_m) begin
                        phase_m[k] = PH_LONG;
                        r.fire = 1'b1;
                        r.code = EV_LONG;
                    end
                end
            end
            PH_LONG: begin
                if (!p) begin
                    phase_m[k] = PH_UP;
                    r.fire = 1'b1;
                    r.code = EV_UP;
                end
            end
            PH_UP: begin
                if (!p) begin
                    phase_m[k] = PH_IDLE;
                    hold_m[k]  = '0;
                end else begin
                    r.fire = 1'b1;
                    r.code = EV_UP;
                end
            end
            default: phase_m[k] = p ? PH_CONFIRM : PH_IDLE;
        endcase
        return r;
    endfunction

    // drive one sample beat in bursts; called and returns at a falling edge
    task automatic send_sample(input t_in_item s, input t_row_kind kind,
                               input logic [1:0] typed_code);
        t_key_event hit;
        t_out_item  exp_ev;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= s;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        hit = track_key(s);
        exp_ev.event_key = s.key_index;
        case (kind)
            ROW_EVENT: begin
                exp_ev.key_event = typed_code;
                pending_events.push_back(exp_ev);
            end
            ROW_FOLLOW: begin
                exp_ev.key_event = hit.code;
                if (hit.fire) pending_events.push_back(exp_ev);
            end
            default: ;
        endcase
        @(negedge clk);
    endtask

    // hold the sender until every expected event is out, then let the pipe empty
    task automatic wait_quiet();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic load_settings(input logic [COUNT_W-1:0] ticks,
                                 input logic [MASK_W-1:0] on_mask,
                                 input logic [MASK_W-1:0] lvl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LONG_PRESS_TICKS;
        cfg_wdata <= ticks;
        @(negedge clk);
        cfg_index <= CFG_KEY_ENABLE_MASK;
        cfg_wdata <= {8'h00, on_mask};
        @(negedge clk);
        cfg_index <= CFG_PRESSED_LEVEL_MASK;
        cfg_wdata <= {8'h00, lvl};
        @(negedge clk);
        cfg_we   <= 1'b0;
        ticks_m  = ticks;
        key_on_m = on_mask;
        level_m  = lvl;
    endtask

    // press and release runs per key with random content and some glitches
    task automatic run_random(input int unsigned n, input int unsigned span,
                              input int unsigned flip_odds);
        t_in_item s;
        int unsigned k;
        for (int unsigned i = 0; i < n; i++) begin
            k = $urandom_range(0, span - 1);
            if ($urandom_range(0, flip_odds - 1) == 0) want_press[k] = !want_press[k];
            s.key_index = k[KEY_W-1:0];
            if ($urandom_range(0, 15) == 0)
                s.pin_level = 1'($urandom_range(0, 1));
            else
                s.pin_level = want_press[k] ? level_m[k] : !level_m[k];
            send_sample(s, ROW_FOLLOW, EV_DOWN);
            if ($urandom_range(0, 299) == 0) wait_quiet();
        end
    endtask

    // receiver stall pattern, style changes when its random span runs out
    always @(negedge clk) begin
        if (stall_span == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            stall_span  <= $urandom_range(50, 300);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_style)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= stall_span[2];
        endcase
    end

    // compare each output beat with the oldest expected event
    always @(posedge clk) begin : check_events
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_events.size() == 0) begin
                log_mismatch($sformatf("unexpected event key %0d code %0d",
                                       o_out_item.event_key, o_out_item.key_event));
            end else begin
                want = pending_events.pop_front();
                if (o_out_item.event_key != want.event_key)
                    log_mismatch($sformatf("event_key got %0d want %0d",
                                           o_out_item.event_key, want.event_key));
                if (o_out_item.key_event != want.key_event)
                    log_mismatch($sformatf("key_event got %0d want %0d (key %0d)",
                                           o_out_item.key_event, want.key_event,
                                           want.event_key));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_in_item s;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // scripted rows
        load_settings(16'd2, 8'hFF, 8'h80);
        for (int unsigned i = 0; i < SCRIPT_LEN; i++) begin
            s.key_index = SCRIPT[i].key;
            s.pin_level = SCRIPT[i].pin;
            send_sample(s, SCRIPT[i].kind, SCRIPT[i].code);
        end
        wait_quiet();

        // randomized phases
        load_settings(16'd1, 8'hFF, 8'h00);
        run_random(250, NUM_KEYS, 4);
        wait_quiet();
        load_settings(16'd0, 8'h5A, 8'hFF);
        run_random(200, NUM_KEYS, 3);
        wait_quiet();
        load_settings(16'd3, 8'h00, 8'h3C);
        run_random(100, NUM_KEYS, 4);
        wait_quiet();
        for (int unsigned ph = 0; ph < 4; ph++) begin
            load_settings(16'($urandom_range(1, 8)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            run_random(150, NUM_KEYS, $urandom_range(3, 10));
            wait_quiet();
        end
        load_settings(16'd40, 8'hFF, 8'hA5);
        run_random(150, 2, 64);
        wait_quiet();

        // full threshold: release key 5 to idle, then hold well short of the long event
        load_settings(16'hFFFF, 8'hFF, 8'h20);
        s.key_index = 3'd5;
        s.pin_level = 1'b0;
        repeat (2) send_sample(s, ROW_FOLLOW, EV_DOWN);
        s.pin_level = 1'b1;
        for (int unsigned i = 0; i < HOLD_BEATS; i++) send_sample(s, ROW_FOLLOW, EV_DOWN);
        s.pin_level = 1'b0;
        repeat (2) send_sample(s, ROW_FOLLOW, EV_DOWN);

        wait_quiet();
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/kped_pkg.sv
rtl/kped_state_mem.sv
rtl/kped_update.sv
rtl/key_press_event_detector_top.sv
rtl/kped_checker.sv
tb/key_press_event_detector_top_tb.sv
